// ===== hw/rtl/tcf_pkg.sv =====
// ----------------------------------------------------------------------------
// tcf_pkg - shared types and constants of the tilt complementary filter
// Word formats, CORDIC arc table and fixed-point constants used by all stages.
// ----------------------------------------------------------------------------
package tcf_pkg;

    localparam int IN_W        = 16;
    localparam int X_W         = 35;     // CORDIC x/y: input * 2^16 plus gain growth
    localparam int Z_W         = 30;     // CORDIC angle in 2^-20 degree
    localparam int TABLE_FRAC  = 20;
    localparam int TABLE_LEN   = 24;
    localparam int ARC_IDX_W   = 5;
    localparam int M_W         = 32;     // gyro increment numerator after the /16
    localparam int N_W         = 21;     // gyro rate numerator
    localparam int QD_W        = 24;
    localparam int QR_W        = 16;
    localparam int D_W         = 25;
    localparam int Q_DEPTH     = 2;

    localparam int ALPHA_ONE   = 32768;
    localparam int BLEND_RESET = 31130;
    localparam int PITCH_LIMIT = 46080;
    localparam int RATE_LIMIT  = 32000;
    localparam int RATE_NUM    = 40;
    localparam int RATE_BIAS   = 20;
    localparam int M_BIAS      = 102;    // half of 3280, divided by 16 and floored

    localparam logic signed [Z_W-1:0] Z90 = Z_W'(90 * (1 << TABLE_FRAC));

    // 3280 = 16 * 205; the /16 is exact, 205 goes through a reciprocal.
    localparam int DEN_D          = 205;
    localparam int RECIP_D_SHIFT  = 39;
    localparam logic [31:0] RECIP_D = 32'((64'd1 << RECIP_D_SHIFT) / 64'd205);
    localparam int DEN_R          = 41;
    localparam int RECIP_R_SHIFT  = 27;
    localparam logic [21:0] RECIP_R = 22'((64'd1 << RECIP_R_SHIFT) / 64'd41);

    typedef struct packed {
        logic signed [IN_W-1:0] accel_y;
        logic signed [IN_W-1:0] accel_z;
        logic signed [IN_W-1:0] gyro_x;
    } t_in_word;

    typedef struct packed {
        logic signed [16:0]     pitch_angle;
        logic signed [IN_W-1:0] gyro_rate;
    } t_out_word;

    typedef struct packed {
        logic signed [X_W-1:0] x;
        logic signed [X_W-1:0] y;
        logic signed [Z_W-1:0] z;
        logic                  zero;
        logic                  neg;
        logic [M_W-1:0]        m;
        logic [N_W-1:0]        n;
    } t_job;

    // atan(2^-i) in degrees, scaled by 2^20
    function automatic logic signed [Z_W-1:0] arc_entry(input logic [ARC_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 30'sd47185920;
            5'd1:    v = 30'sd27855475;
            5'd2:    v = 30'sd14718068;
            5'd3:    v = 30'sd7471121;
            5'd4:    v = 30'sd3750058;
            5'd5:    v = 30'sd1876857;
            5'd6:    v = 30'sd938658;
            5'd7:    v = 30'sd469357;
            5'd8:    v = 30'sd234682;
            5'd9:    v = 30'sd117342;
            5'd10:   v = 30'sd58671;
            5'd11:   v = 30'sd29335;
            5'd12:   v = 30'sd14668;
            5'd13:   v = 30'sd7334;
            5'd14:   v = 30'sd3667;
            5'd15:   v = 30'sd1833;
            5'd16:   v = 30'sd917;
            5'd17:   v = 30'sd458;
            5'd18:   v = 30'sd229;
            5'd19:   v = 30'sd115;
            5'd20:   v = 30'sd57;
            5'd21:   v = 30'sd29;
            5'd22:   v = 30'sd14;
            5'd23:   v = 30'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/tcf_front.sv =====
// ----------------------------------------------------------------------------
// tcf_front - input register and sample classification
// Holds one input word, sorts it into CORDIC quadrant and special cases and
// prepares the gyro numerators, then pushes the job into the queue.
// ----------------------------------------------------------------------------
module tcf_front #(
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  tcf_pkg::t_in_word i_in_data,
    output logic              o_push,
    output tcf_pkg::t_job     o_job,
    input  logic              i_full
);
    import tcf_pkg::*;

    localparam int M_SHIFT = ANGLE_FRAC_BITS - 4;

    logic                   r_valid;
    logic                   n_valid;
    t_in_word               r_word;
    logic signed [IN_W-1:0] ay;
    logic signed [IN_W-1:0] az;
    logic signed [IN_W-1:0] gx;
    logic signed [X_W-1:0]  xs;
    logic signed [X_W-1:0]  ys;
    logic [IN_W:0]          gneg;
    logic [IN_W-1:0]        mag;
    logic                   accept;

    assign o_in_stall = r_valid && i_full;
    assign o_push     = r_valid && !i_full;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= i_in_data;
        end
    end

    assign ay   = r_word.accel_y;
    assign az   = r_word.accel_z;
    assign gx   = r_word.gyro_x;
    assign xs   = X_W'(az) <<< 16;
    assign ys   = X_W'(ay) <<< 16;
    assign gneg = (IN_W + 1)'(-(IN_W + 1)'(gx));
    assign mag  = gx[IN_W-1] ? gneg[IN_W-1:0] : gx;

    // A vector in the left half plane is turned by a quarter first so the
    // rotator only ever sees x >= 0.
    always_comb begin
        o_job.x = xs;
        o_job.y = ys;
        o_job.z = '0;
        if (az < 0) begin
            if (ay >= 0) begin
                o_job.x = ys;
                o_job.y = -xs;
                o_job.z = Z90;
            end else begin
                o_job.x = -ys;
                o_job.y = xs;
                o_job.z = -Z90;
            end
        end
        o_job.zero = (ay == 0) && (az == 0);
        o_job.neg  = gx[IN_W-1];
        o_job.m    = (M_W'(mag) << M_SHIFT) + M_W'(M_BIAS);
        o_job.n    = N_W'(mag) * N_W'(RATE_NUM) + N_W'(RATE_BIAS);
    end

endmodule

// ===== hw/rtl/tcf_queue.sv =====
// ----------------------------------------------------------------------------
// tcf_queue - short job queue between front and back
// Two-entry FIFO of classified jobs; lets either side stall on its own.
// ----------------------------------------------------------------------------
module tcf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tcf_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_pop,
    output tcf_pkg::t_job o_job
);
    import tcf_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_job             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue read while empty");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == CNT_W'($past(r_count) + 1'b1)))
        else $error("queue count did not follow a push");

endmodule

// ===== hw/rtl/tcf_back.sv =====
// ----------------------------------------------------------------------------
// tcf_back - CORDIC rotator, gyro scaling, blend and output register
// Runs one job at a time: shared vectoring CORDIC, reciprocal divisions of
// the gyro word in the same cycles, blend multiply and sum, pitch rounding.
// ----------------------------------------------------------------------------
module tcf_back #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [15:0]        i_blend,
    input  logic               i_q_valid,
    input  tcf_pkg::t_job      i_job,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tcf_pkg::t_out_word o_out_data
);
    import tcf_pkg::*;

    localparam int STEP_W  = $clog2(CORDIC_STEPS);
    localparam int AS      = TABLE_FRAC - ANGLE_FRAC_BITS;
    localparam int ROUND_A = (AS > 0) ? (1 << (AS - 1)) : 0;
    localparam int PS      = ANGLE_FRAC_BITS - 8;
    localparam int ROUND_P = (PS > 0) ? (1 << (PS - 1)) : 0;
    localparam int P1_W    = 17 + 33;
    localparam int P2_W    = 17 + Z_W;
    localparam int SUM_W   = P1_W + 2;
    localparam longint INT32_HI = 64'sd2147483647;
    localparam longint INT32_LO = -64'sd2147483648;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ROT   = 6'b000010,
        S_MUL1  = 6'b000100,
        S_MUL2  = 6'b001000,
        S_SUM   = 6'b010000,
        S_PITCH = 6'b100000
    } t_state;

    t_state                 r_state;
    t_state                 n_state;
    logic [STEP_W-1:0]      r_step;
    logic signed [X_W-1:0]  r_x;
    logic signed [X_W-1:0]  r_y;
    logic signed [Z_W-1:0]  r_z;
    logic                   r_zero;
    logic                   r_neg;
    logic [M_W-1:0]         r_m;
    logic [N_W-1:0]         r_n;
    logic [63:0]            r_prod_d;
    logic [QD_W-1:0]        r_qd;
    logic [N_W+21:0]        r_prod_r;
    logic [QR_W-1:0]        r_qr;
    logic signed [D_W-1:0]  r_delta;
    logic signed [15:0]     r_rate;
    logic signed [P1_W-1:0] r_p1;
    logic signed [P2_W-1:0] r_p2;
    logic signed [31:0]     r_angle;
    logic                   r_out_valid;
    t_out_word              r_out_word;

    logic signed [X_W-1:0]  dx_c;
    logic signed [X_W-1:0]  dy_c;
    logic signed [Z_W-1:0]  arc_c;
    logic                   last_step;
    logic                   out_free;
    logic                   load_out;
    logic [M_W-1:0]         qd_mul_c;
    logic [M_W-1:0]         rem_d_c;
    logic [QD_W-1:0]        qd_fix_c;
    logic signed [D_W-1:0]  dmag_c;
    logic [N_W-1:0]         qr_mul_c;
    logic [N_W-1:0]         rem_r_c;
    logic [QR_W-1:0]        qr_fix_c;
    logic signed [QR_W:0]   rmag_c;
    logic signed [QR_W:0]   rsig_c;
    logic signed [15:0]     rate_c;
    logic [15:0]            alpha_c;
    logic [15:0]            beta_c;
    logic signed [16:0]     alpha_s;
    logic signed [16:0]     beta_s;
    logic signed [32:0]     fad_c;
    logic signed [P1_W-1:0] p1_c;
    logic signed [Z_W-1:0]  accel_c;
    logic signed [P2_W-1:0] p2_c;
    logic signed [SUM_W-1:0] sum_c;
    logic signed [SUM_W-1:0] sh_c;
    logic signed [31:0]     angle_c;
    logic signed [32:0]     pr_c;
    logic signed [16:0]     pitch_c;

    assign o_pop       = (r_state == S_IDLE) && i_q_valid;
    assign last_step   = (r_step == STEP_W'(CORDIC_STEPS - 1));
    assign out_free    = !r_out_valid || !i_out_stall;
    assign load_out    = (r_state == S_PITCH) && out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_word;

    // One rotation per cycle through the shared shifter and adder pair.
    assign dx_c  = r_y >>> r_step;
    assign dy_c  = r_x >>> r_step;
    assign arc_c = arc_entry(ARC_IDX_W'(r_step));

    // Reciprocal quotients can come out one low; a single compare fixes that.
    assign qd_mul_c = M_W'(r_qd) * M_W'(DEN_D);
    assign rem_d_c  = r_m - qd_mul_c;
    assign qd_fix_c = (rem_d_c >= M_W'(DEN_D)) ? r_qd + 1'b1 : r_qd;
    assign dmag_c   = {1'b0, qd_fix_c};
    assign qr_mul_c = N_W'(r_qr) * N_W'(DEN_R);
    assign rem_r_c  = r_n - qr_mul_c;
    assign qr_fix_c = (rem_r_c >= N_W'(DEN_R)) ? r_qr + 1'b1 : r_qr;
    assign rmag_c   = {1'b0, qr_fix_c};
    assign rsig_c   = r_neg ? -rmag_c : rmag_c;

    always_comb begin
        if (rsig_c > (QR_W + 1)'(RATE_LIMIT)) begin
            rate_c = 16'(RATE_LIMIT);
        end else if (rsig_c < -(QR_W + 1)'(RATE_LIMIT)) begin
            rate_c = -16'(RATE_LIMIT);
        end else begin
            rate_c = 16'(rsig_c);
        end
    end

    assign alpha_c = (i_blend > 16'(ALPHA_ONE)) ? 16'(ALPHA_ONE) : i_blend;
    assign beta_c  = 16'(ALPHA_ONE) - alpha_c;
    assign alpha_s = {1'b0, alpha_c};
    assign beta_s  = {1'b0, beta_c};
    assign fad_c   = 33'(r_angle) + 33'(r_delta);
    assign p1_c    = alpha_s * fad_c;
    assign accel_c = r_zero ? Z_W'(0) : ((r_z + Z_W'(ROUND_A)) >>> AS);
    assign p2_c    = beta_s * accel_c;
    assign sum_c   = SUM_W'(r_p1) + SUM_W'(r_p2) + SUM_W'(ALPHA_ONE / 2);
    assign sh_c    = sum_c >>> 15;

    always_comb begin
        if (sh_c > SUM_W'(INT32_HI)) begin
            angle_c = 32'(INT32_HI);
        end else if (sh_c < SUM_W'(INT32_LO)) begin
            angle_c = 32'(INT32_LO);
        end else begin
            angle_c = 32'(sh_c);
        end
    end

    assign pr_c = (33'(r_angle) + 33'(ROUND_P)) >>> PS;

    always_comb begin
        if (pr_c > 33'(PITCH_LIMIT)) begin
            pitch_c = 17'(PITCH_LIMIT);
        end else if (pr_c < -33'(PITCH_LIMIT)) begin
            pitch_c = -17'(PITCH_LIMIT);
        end else begin
            pitch_c = 17'(pr_c);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = S_ROT;
                end
            end
            S_ROT: begin
                if (last_step) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_SUM;
            S_SUM:   n_state = S_PITCH;
            S_PITCH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_angle     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_step <= '0;
            end else if (r_state == S_ROT && !last_step) begin
                r_step <= r_step + 1'b1;
            end
            if (r_state == S_SUM) begin
                r_angle <= angle_c;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_x    <= i_job.x;
            r_y    <= i_job.y;
            r_z    <= i_job.z;
            r_zero <= i_job.zero;
            r_neg  <= i_job.neg;
            r_m    <= i_job.m;
            r_n    <= i_job.n;
        end else if (r_state == S_ROT) begin
            if (r_y > 0) begin
                r_x <= r_x + dx_c;
                r_y <= r_y - dy_c;
                r_z <= r_z + arc_c;
            end else begin
                r_x <= r_x - dx_c;
                r_y <= r_y + dy_c;
                r_z <= r_z - arc_c;
            end
        end

        // The gyro divisions ride along in the first rotation cycles.
        if (r_state == S_ROT) begin
            if (r_step == STEP_W'(0)) begin
                r_prod_d <= 64'(r_m) * 64'(RECIP_D);
            end
            if (r_step == STEP_W'(1)) begin
                r_qd     <= r_prod_d[RECIP_D_SHIFT+QD_W-1:RECIP_D_SHIFT];
                r_prod_r <= (N_W + 22)'(r_n) * (N_W + 22)'(RECIP_R);
            end
            if (r_step == STEP_W'(2)) begin
                r_delta <= r_neg ? -dmag_c : dmag_c;
                r_qr    <= r_prod_r[RECIP_R_SHIFT+QR_W-1:RECIP_R_SHIFT];
            end
            if (r_step == STEP_W'(3)) begin
                r_rate <= rate_c;
            end
        end

        if (r_state == S_MUL1) begin
            r_p1 <= p1_c;
        end
        if (r_state == S_MUL2) begin
            r_p2 <= p2_c;
        end
        if (load_out) begin
            r_out_word.pitch_angle <= pitch_c;
            r_out_word.gyro_rate   <= r_rate;
        end
    end

    a_pop_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_q_valid) |=> (r_state == S_ROT))
        else $error("job taken from queue without starting rotation");

    a_angle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SUM) |=> $stable(r_angle))
        else $error("filtered angle changed outside the update cycle");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_PITCH))
        else $error("result word loaded outside the pitch cycle");

endmodule

// ===== hw/rtl/tilt_complementary_filter.sv =====
// ----------------------------------------------------------------------------
// tilt_complementary_filter - accel/gyro complementary tilt filter
// Accel tilt by CORDIC atan2, gyro rate scaling and a weighted blend into a
// filtered pitch angle; one result word for every input word.
//
//   channel  direction  handshake          word
//   in       input      valid / stall      accel_y, accel_z, gyro_x
//   out      output     valid / stall      pitch_angle, gyro_rate
//   cfg      input      valid / ready      blend_weight (Q1.15)
//
// The back end works on one word at a time: the fetch, one CORDIC rotation
// per step on the single shared rotator, two blend multiplies, the state
// update and the pitch rounding, which waits while the output is stalled.
// The front register and a two-entry queue take new words while the back works.
// Reset is synchronous and active low; it clears the filtered angle and loads
// blend_weight with 0.95. The output register holds a word under stall while
// the back end already finishes the next one.
// ----------------------------------------------------------------------------
module tilt_complementary_filter #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tcf_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tcf_pkg::t_out_word o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data
);
    import tcf_pkg::*;

    logic [15:0] r_blend;
    logic        push;
    logic        full;
    logic        q_valid;
    logic        pop;
    t_job        push_job;
    t_job        head_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend <= 16'(BLEND_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_blend <= i_cfg_data;
        end
    end

    tcf_front #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_push     (push),
        .o_job      (push_job),
        .i_full     (full)
    );

    tcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_job   (head_job)
    );

    tcf_back #(
        .CORDIC_STEPS    (CORDIC_STEPS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_blend     (r_blend),
        .i_q_valid   (q_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== sim/tilt_angle_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tilt_angle_checker - result checker for the tilt complementary filter
// Watches the sample, result and blend weight channels. Every accepted sample
// word is run through a local model of the CORDIC tilt, the gyro scaling and
// the weighted blend, and each accepted result word is compared field by field
// with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tilt_angle_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  tcf_pkg::t_in_word  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  tcf_pkg::t_out_word i_out_data,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [15:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_words_pending
);

    localparam int     STEPS         = 16;
    localparam int     FRAC          = 16;
    localparam int     ARC_FRAC      = 20;
    localparam int     REPORT_LIMIT  = 10;
    localparam longint ONE_Q15       = 32768;
    localparam longint BLEND_AT_RST  = 31130;
    localparam longint PITCH_MAX     = 46080;
    localparam longint RATE_MAX      = 32000;
    localparam longint INT32_HI      = (64'sd1 <<< 31) - 64'sd1;
    localparam longint INT32_LO      = -(64'sd1 <<< 31);

    // atan(2^-i) in degrees, scaled by 2^20.
    localparam longint ARC_DEG [24] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
        469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    tcf_pkg::t_out_word pending_words[$];
    longint             tilt_acc;
    longint             blend_q15;
    int                 error_total;

    function automatic longint div_nearest(input longint num, input longint den);
        longint mag;
        mag = (num < 0) ? -num : num;
        mag = (mag + den / 2) / den;
        return (num < 0) ? -mag : mag;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // atan2(ay, az) in 2^-20 degree by vectoring rotations.
    function automatic longint accel_tilt(input longint ay, input longint az);
        longint x;
        longint y;
        longint z;
        longint t;
        longint dx;
        longint dy;
        if (ay == 0 && az == 0) begin
            return 0;
        end
        x = az * 65536;
        y = ay * 65536;
        z = 0;
        // Left half plane: turn the vector by 90 degrees first.
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = 64'sd90 * (64'sd1 <<< ARC_FRAC);
            end else begin
                x = -y;
                y = t;
                z = -64'sd90 * (64'sd1 <<< ARC_FRAC);
            end
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx;
                y = y - dy;
                z = z + ARC_DEG[i];
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - ARC_DEG[i];
            end
        end
        return z;
    endfunction

    // Advances the filtered angle by one sample and returns the result word.
    function automatic tcf_pkg::t_out_word filter_sample(input tcf_pkg::t_in_word w);
        tcf_pkg::t_out_word r;
        longint             gx;
        longint             accel;
        longint             delta;
        longint             rate;
        longint             alpha;
        longint             sum;
        longint             pitch;
        gx    = w.gyro_x;
        accel = accel_tilt(w.accel_y, w.accel_z);
        accel = (accel + (64'sd1 <<< (ARC_FRAC - FRAC - 1))) >>> (ARC_FRAC - FRAC);
        // 0.005 s / 16.4 LSB per deg/s is exactly 1/3280.
        delta = div_nearest(gx * (64'sd1 <<< FRAC), 3280);
        rate  = clip(div_nearest(gx * 40, 41), -RATE_MAX, RATE_MAX);
        alpha = (blend_q15 > ONE_Q15) ? ONE_Q15 : blend_q15;
        sum   = alpha * (tilt_acc + delta) + (ONE_Q15 - alpha) * accel;
        tilt_acc = clip((sum + ONE_Q15 / 2) >>> 15, INT32_LO, INT32_HI);
        // Only the output saturates at 180 degrees; the state keeps its value.
        pitch = clip((tilt_acc + (64'sd1 <<< (FRAC - 9))) >>> (FRAC - 8),
                     -PITCH_MAX, PITCH_MAX);
        r.pitch_angle = pitch[16:0];
        r.gyro_rate   = rate[15:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        tcf_pkg::t_out_word want;
        if (!i_rst_n) begin
            pending_words.delete();
            tilt_acc  = 0;
            blend_q15 = BLEND_AT_RST;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                blend_q15 = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                pending_words.push_back(filter_sample(i_in_data));
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_words.size() == 0) begin
                    error_total++;
                    if (error_total <= REPORT_LIMIT) begin
                        $display("%0t: result word with none expected: pitch %0d rate %0d",
                                 $realtime, i_out_data.pitch_angle, i_out_data.gyro_rate);
                    end
                end else begin
                    want = pending_words.pop_front();
                    if (i_out_data.pitch_angle !== want.pitch_angle ||
                        i_out_data.gyro_rate !== want.gyro_rate) begin
                        error_total++;
                        if (error_total <= REPORT_LIMIT) begin
                            $display("%0t: mismatch: pitch exp %0d got %0d, rate exp %0d got %0d",
                                     $realtime, want.pitch_angle, i_out_data.pitch_angle,
                                     want.gyro_rate, i_out_data.gyro_rate);
                        end
                    end
                end
            end
        end
        o_fail_count    <= error_total;
        o_words_pending <= pending_words.size();
    end

endmodule

// ===== sim/tilt_complementary_filter_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tilt_complementary_filter_test - testbench top of the tilt complementary filter
// Drives corner samples and random sensor words through the filter under
// several blend weights and idle patterns, including gyro-only runs long
// enough to clamp the pitch output both ways. The checker beside the
// block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tilt_complementary_filter_test;

    logic               i_clk;
    logic               i_rst_n        = 1'b0;
    logic               in_valid       = 1'b0;
    logic               in_stall;
    tcf_pkg::t_in_word  in_data        = '0;
    logic               out_valid;
    logic               out_stall      = 1'b0;
    tcf_pkg::t_out_word out_data;
    logic               cfg_valid      = 1'b0;
    logic               cfg_ready;
    logic [15:0]        cfg_data       = '0;
    int                 fail_count;
    int                 words_pending;
    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;
    int                 hold_req       = 0;

    tilt_complementary_filter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    tilt_angle_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_data       (in_data),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_data      (out_data),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_words_pending (words_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Result side: random stall, or a long hold-off when one is requested.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    function automatic logic signed [15:0] pick_sample();
        logic signed [15:0] v;
        case ($urandom_range(7))
            0:       v = 16'sh7FFF;
            1:       v = 16'sh8000;
            2:       v = '0;
            3:       v = '1;
            4:       v = 16'($urandom_range(64) - 32);
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    task automatic send_word(input logic signed [15:0] ay, input logic signed [15:0] az,
                             input logic signed [15:0] gx);
        tcf_pkg::t_in_word w;
        w.accel_y = ay;
        w.accel_z = az;
        w.gyro_x  = gx;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge i_clk); while (in_stall);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_word(pick_sample(), pick_sample(), pick_sample());
    endtask

    // Stops offering words and waits until every predicted result has come.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
    endtask

    task automatic set_blend(input logic [15:0] weight);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= weight;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Corner samples at the reset blend weight, no idling.
        send_word(0, 0, 0);
        send_word(0, -1, 0);
        send_word(0, -32768, 0);
        send_word(0, 32767, 32767);
        send_word(32767, 0, -32768);
        send_word(-32768, 0, 1);
        send_word(-32768, -32768, -1);
        send_word(32767, -32768, 16);
        send_word(-1, -32768, -16);
        send_word(1, -32768, 41);
        send_word(32767, 32767, -41);
        send_word(-32768, 32767, 1640);
        send_word(1, 1, -1640);
        send_word(-1, 1, 3280);
        repeat (6) send_word(0, -32768, 32767);

        // Long hold-off on the result side while samples keep coming.
        send_random(100);
        hold_req = 400;
        send_random(150);

        set_blend(16'd0);
        send_idle_pct  = 59;
        send_random(250);

        set_blend(16'd32768);
        send_idle_pct  = 0;
        recv_stall_pct = 59;
        send_random(250);

        set_blend(16'($urandom_range(32767, 1)));
        send_idle_pct  = 30;
        recv_stall_pct = 30;
        send_random(120);
        drain();
        send_random(120);

        // Gyro only, far enough to clamp the pitch output at both ends.
        set_blend(16'hFFFF);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (80) send_word(pick_sample(), pick_sample(), 16'sh7FFF);
        set_blend(16'd0);
        send_word(0, 100, 0);
        set_blend(16'd40000);
        repeat (80) send_word(pick_sample(), pick_sample(), 16'sh8000);

        set_blend(16'd16384);
        send_idle_pct  = 30;
        recv_stall_pct = 30;
        send_random(100);

        drain();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && words_pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
